// ===== rtl/core/egs_pkg.sv =====
// Shared types and constants for the epoch goodness scheduler.
// No dependencies.
`timescale 1ns / 1ps
package egs_pkg;
    localparam logic       MODE_SET   = 1'b0;
    localparam logic       MODE_RESCH = 1'b1;
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_CURR    = 2'd2;
    localparam logic [1:0] ST_WAIT    = 2'd3;
    localparam int         QW         = 9;
    localparam int         GW         = 10;
    localparam logic [QW-1:0] Q_MAX   = 9'd511;
    localparam logic [GW-1:0] G_MAX   = 10'd1023;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_slot;
        logic [1:0] wr_state;
        logic [15:0] wr_prio;
        logic       charge;
        logic [7:0] cur;
        logic [QW-1:0] ticks;
        logic       recompute;
        logic       demote;
        logic       promote;
        logic [7:0] best;
        logic       shift;
    } egs_cmd_t;
endpackage

// ===== rtl/core/egs_cell.sv =====
// One task slot: state, priority, quantum, goodness, plus a shift stage
// that hands its report to the next cell. Depends on egs_pkg.
`timescale 1ns / 1ps
module egs_cell #(
    parameter int IDX        = 0,
    parameter int PRIO_WIDTH = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  egs_pkg::egs_cmd_t      cmd,
    input  logic                   sh_run_in,
    input  logic [egs_pkg::GW-1:0] sh_good_in,
    input  logic [egs_pkg::QW-1:0] sh_q_in,
    output logic                   sh_run_out,
    output logic [egs_pkg::GW-1:0] sh_good_out,
    output logic [egs_pkg::QW-1:0] sh_q_out
);
    logic [1:0]            st_reg;
    logic [PRIO_WIDTH-1:0] pr_reg;
    logic [egs_pkg::QW-1:0] q_reg;
    logic [egs_pkg::GW-1:0] g_reg;
    logic                   srun_reg;
    logic [egs_pkg::GW-1:0] sgood_reg;
    logic [egs_pkg::QW-1:0] sq_reg;
    logic                   run_w;
    logic [16:0]            qsum;
    logic [16:0]            gsum;
    logic [16:0]            pw;
    logic [egs_pkg::QW-1:0] q_next;
    logic [egs_pkg::GW-1:0] g_next;
    logic [1:0]             st_next;
    logic                   me;

    assign me    = (cmd.cur == 8'(IDX));
    assign run_w = (st_reg == egs_pkg::ST_READY) || (st_reg == egs_pkg::ST_CURR);
    assign qsum  = 17'(pr_reg) + 17'(q_reg >> 1);
    assign gsum  = 17'(pr_reg) + 17'(cmd.ticks);
    assign pw    = 17'(pr_reg);

    always_comb begin
        q_next  = q_reg;
        g_next  = g_reg;
        st_next = st_reg;
        if (cmd.wr_en && cmd.wr_slot == 8'(IDX)) begin
            st_next = cmd.wr_state;
        end
        if (cmd.charge && me) begin
            q_next = cmd.ticks;
            g_next = (cmd.ticks == '0) ? '0 :
                     (gsum > 17'(egs_pkg::G_MAX)) ? egs_pkg::G_MAX : gsum[egs_pkg::GW-1:0];
        end
        if (cmd.recompute && st_reg != egs_pkg::ST_FREE) begin
            q_next = (qsum > 17'(egs_pkg::Q_MAX)) ? egs_pkg::Q_MAX : qsum[egs_pkg::QW-1:0];
            g_next = (pw > 17'(egs_pkg::G_MAX)) ? egs_pkg::G_MAX
                   : pw[egs_pkg::GW-1:0];
        end
        if (cmd.demote && me && st_reg == egs_pkg::ST_CURR) begin
            st_next = egs_pkg::ST_READY;
        end
        if (cmd.promote && cmd.best == 8'(IDX)) begin
            st_next = egs_pkg::ST_CURR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= egs_pkg::ST_FREE;
            pr_reg <= '0;
            q_reg  <= '0;
            g_reg  <= '0;
            srun_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            q_reg  <= q_next;
            g_reg  <= g_next;
            if (cmd.wr_en && cmd.wr_slot == 8'(IDX)) begin
                pr_reg <= cmd.wr_prio[PRIO_WIDTH-1:0];
            end
            if (cmd.shift) begin
                srun_reg <= sh_run_in;
            end else begin
                srun_reg <= run_w && (q_reg != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            sgood_reg <= sh_good_in;
            sq_reg    <= sh_q_in;
        end else begin
            sgood_reg <= g_reg;
            sq_reg    <= q_reg;
        end
    end

    assign sh_run_out  = srun_reg;
    assign sh_good_out = sgood_reg;
    assign sh_q_out    = sq_reg;
endmodule

// ===== rtl/core/egs_seq.sv =====
// Sequencer: accepts words, drives cell commands, scans the shifted cell
// reports and holds the result word. Depends on egs_pkg.
`timescale 1ns / 1ps
module egs_seq #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_mode,
    input  logic [5:0]             in_slot,
    input  logic [1:0]             in_state,
    input  logic [7:0]             in_prio,
    input  logic [8:0]             in_ticks,
    output egs_pkg::egs_cmd_t      cmd,
    input  logic                   sh_run,
    input  logic [egs_pkg::GW-1:0] sh_good,
    input  logic [egs_pkg::QW-1:0] sh_q,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [16:0]            out_word
);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [2:0] S_IDLE = 3'd0, S_CHG = 3'd1, S_LD1 = 3'd2, S_CHK = 3'd3,
                           S_REC = 3'd4, S_LD2 = 3'd5, S_SEL = 3'd6, S_DONE = 3'd7;

    logic [2:0]    state_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    cur_reg;
    logic [8:0]    ticks_reg;
    logic          any_reg, found_reg, epoch_reg, ov_reg;
    logic [egs_pkg::GW-1:0] bg_reg;
    logic [egs_pkg::QW-1:0] bq_reg;
    logic [7:0]    best_reg;
    logic [16:0]   word_reg;
    logic [7:0]    idx;
    logic          last;

    // reports leave the chain highest slot first
    assign idx  = 8'(NUM_SLOTS - 1) - 8'(cnt_reg);
    assign last = (cnt_reg == CW'(NUM_SLOTS - 1));
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_word  = word_reg;

    always_comb begin
        cmd = '0;
        cmd.wr_en    = in_valid && in_ready && (in_mode == egs_pkg::MODE_SET)
                       && (9'(in_slot) < 9'(NUM_SLOTS));
        cmd.wr_slot  = 8'(in_slot);
        cmd.wr_state = in_state;
        cmd.wr_prio  = 16'(in_prio);
        cmd.cur      = cur_reg;
        cmd.ticks    = ticks_reg;
        cmd.best     = best_reg;
        cmd.charge   = (state_reg == S_CHG);
        cmd.recompute = (state_reg == S_REC);
        cmd.demote   = (state_reg == S_LD2);
        cmd.promote  = (state_reg == S_DONE) && found_reg;
        cmd.shift    = (state_reg == S_CHK) || (state_reg == S_SEL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            cur_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            if (ov_reg && out_ready) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: if (in_valid && in_ready && in_mode == egs_pkg::MODE_RESCH) begin
                    ticks_reg <= in_ticks;
                    state_reg <= S_CHG;
                end
                S_CHG: state_reg <= S_LD1;
                S_LD1: begin
                    cnt_reg   <= '0;
                    any_reg   <= 1'b0;
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    any_reg <= any_reg | sh_run;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last) begin
                        state_reg <= (any_reg | sh_run) ? S_LD2 : S_REC;
                        epoch_reg <= !(any_reg | sh_run);
                    end
                end
                S_REC: state_reg <= S_LD2;
                S_LD2: begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    bg_reg    <= '0;
                    bq_reg    <= '0;
                    best_reg  <= '0;
                    state_reg <= S_SEL;
                end
                S_SEL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    // highest index scanned first, so only strictly greater wins
                    if (sh_run && (!found_reg || sh_good > bg_reg)) begin
                        found_reg <= 1'b1;
                        bg_reg    <= sh_good;
                        bq_reg    <= sh_q;
                        best_reg  <= idx;
                    end
                    if (last) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    cur_reg   <= best_reg;
                    word_reg  <= {found_reg, epoch_reg, bq_reg, best_reg[5:0]};
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/epoch_goodness_scheduler.sv =====
// Top level of the epoch goodness scheduler: sequencer plus a chain of
// slot cells. Depends on egs_pkg, egs_seq, egs_cell.
//
// Usage: s_ words carry set-entry (mode 0) and reschedule (mode 1)
// requests. A set entry is absorbed on acceptance and gives no m_ word.
// A reschedule gives one m_ word. To build it, the chain of cells is
// unloaded twice, one slot a cycle (epoch check, then selection), with a
// recompute of every non-free slot between the two when a new epoch
// starts. One request is processed at a time;
// s_axis_tready is low while a reschedule runs or its result waits.
// A result word holds in its output register until m_axis_tready.
// Reset (aresetn low, synchronous) frees all slots, zeroes priority,
// quantum, goodness and the current slot.
`timescale 1ns / 1ps
module epoch_goodness_scheduler #(
    parameter int NUM_SLOTS  = 64,
    parameter int PRIO_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [0:0]  s_axis_tuser,  // mode
    input  logic [31:0] s_axis_tdata,  // slot[5:0] proc_state[7:6] priority_req[15:8]
                                       // remaining_ticks[24:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // next_slot[5:0] quantum_loaded[14:6]
                                       // new_epoch[15] found[16]
);
    egs_pkg::egs_cmd_t      cmd;
    logic                   run_c [NUM_SLOTS+1];
    logic [egs_pkg::GW-1:0] good_c [NUM_SLOTS+1];
    logic [egs_pkg::QW-1:0] q_c [NUM_SLOTS+1];
    logic [16:0]            word;

    assign run_c[0]  = 1'b0;
    assign good_c[0] = '0;
    assign q_c[0]    = '0;

    egs_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_mode(s_axis_tuser[0]), .in_slot(s_axis_tdata[5:0]),
        .in_state(s_axis_tdata[7:6]), .in_prio(s_axis_tdata[15:8]),
        .in_ticks(s_axis_tdata[24:16]),
        .cmd(cmd),
        .sh_run(run_c[NUM_SLOTS]), .sh_good(good_c[NUM_SLOTS]), .sh_q(q_c[NUM_SLOTS]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word(word)
    );

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        egs_cell #(.IDX(i), .PRIO_WIDTH(PRIO_WIDTH)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
            .sh_run_in(run_c[i]), .sh_good_in(good_c[i]), .sh_q_in(q_c[i]),
            .sh_run_out(run_c[i+1]), .sh_good_out(good_c[i+1]), .sh_q_out(q_c[i+1])
        );
    end

    assign m_axis_tdata = {7'd0, word};
endmodule

// ===== rtl/core/egs_checker.sv =====
// Port-level checks for the epoch goodness scheduler, bound to the top.
// Depends on epoch_goodness_scheduler.
`timescale 1ns / 1ps
module egs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_nf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[14:0] == 15'd0)
        else $error("fallback result not zero");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
        else $error("padding not zero");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result right after input word");
endmodule

bind epoch_goodness_scheduler egs_checker u_egs_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== test/epoch_goodness_scheduler_tb.sv =====
// Self-checking testbench for epoch_goodness_scheduler: directed and random
// set-entry and reschedule words against a slot-table predictor.
// Depends on egs_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module epoch_goodness_scheduler_tb;
    localparam int SLOTS    = 64;
    localparam int LATENCY  = 2 * SLOTS + 6;
    localparam int MAX_CYC  = 2000000;

    typedef struct packed {
        logic [5:0] next_slot;
        logic [8:0] quantum;
        logic       epoch;
        logic       found;
    } pick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [0:0]  s_axis_tuser = '0;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    logic [1:0]  tbl_state [SLOTS];
    logic [7:0]  tbl_prio [SLOTS];
    logic [8:0]  tbl_quant [SLOTS];
    logic [9:0]  tbl_good [SLOTS];
    logic [5:0]  run_slot;
    pick_t       pick_q [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          burst = 1'b0;

    epoch_goodness_scheduler #(.NUM_SLOTS(SLOTS), .PRIO_WIDTH(8)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit runnable(int i);
        return tbl_state[i] == egs_pkg::ST_READY || tbl_state[i] == egs_pkg::ST_CURR;
    endfunction

    task automatic predict_pick(logic [8:0] ticks);
        pick_t p;
        int    cur;
        bit    epoch;
        bit    hit;
        int    best;
        int    best_g;
        int    v;
        cur = run_slot;
        epoch = 1'b1;
        hit = 1'b0;
        best = 0;
        best_g = 0;
        tbl_quant[cur] = ticks;
        v = tbl_prio[cur] + ticks;
        tbl_good[cur] = (ticks == 0) ? 10'd0 : (v > 1023 ? egs_pkg::G_MAX : v[9:0]);
        for (int i = 0; i < SLOTS; i++)
            if (runnable(i) && tbl_quant[i] != 0) epoch = 1'b0;
        if (epoch) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_state[i] != egs_pkg::ST_FREE) begin
                    v = tbl_prio[i] + (tbl_quant[i] >> 1);
                    tbl_quant[i] = v > 511 ? egs_pkg::Q_MAX : v[8:0];
                    tbl_good[i] = {2'b00, tbl_prio[i]};
                end
            end
        end
        if (tbl_state[cur] == egs_pkg::ST_CURR) tbl_state[cur] = egs_pkg::ST_READY;
        for (int i = 0; i < SLOTS; i++) begin
            if (runnable(i) && tbl_quant[i] != 0 && tbl_good[i] >= best_g) begin
                best_g = tbl_good[i];
                best = i;
                hit = 1'b1;
            end
        end
        if (hit) begin
            tbl_state[best] = egs_pkg::ST_CURR;
            run_slot = 6'(best);
            p.quantum = tbl_quant[best];
        end else begin
            run_slot = '0;
            p.quantum = '0;
        end
        p.next_slot = run_slot;
        p.epoch = epoch;
        p.found = hit;
        pick_q.push_back(p);
    endtask

    task automatic send_word(logic mode, logic [5:0] slot, logic [1:0] st,
                             logic [7:0] prio, logic [8:0] ticks);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {7'b0, ticks, prio, st, slot};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (mode == egs_pkg::MODE_SET) begin
            tbl_state[slot] = st;
            tbl_prio[slot] = prio;
        end else begin
            predict_pick(ticks);
        end
    endtask

    task automatic set_slot(int slot, logic [1:0] st, int prio);
        send_word(egs_pkg::MODE_SET, slot[5:0], st, prio[7:0], 9'($urandom));
    endtask

    task automatic resched(int ticks);
        send_word(egs_pkg::MODE_RESCH, 6'($urandom), 2'($urandom), 8'($urandom),
                  ticks[8:0]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pick_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_table();
        resched(0);
        resched(510);
    endtask

    task automatic test_extremes();
        set_slot(63, egs_pkg::ST_READY, 255);
        set_slot(0, egs_pkg::ST_READY, 0);
        resched(0);
        resched(510);
        set_slot(5, egs_pkg::ST_WAIT, 200);
        set_slot(1, egs_pkg::ST_FREE, 128);
        resched(1);
    endtask

    task automatic test_ties_and_current();
        set_slot(10, egs_pkg::ST_READY, 100);
        set_slot(20, egs_pkg::ST_READY, 100);
        set_slot(30, egs_pkg::ST_CURR, 100);
        resched(0);
        resched(0);
        resched(255);
        set_slot(63, egs_pkg::ST_FREE, 0);
        set_slot(10, egs_pkg::ST_FREE, 0);
        set_slot(20, egs_pkg::ST_FREE, 0);
        set_slot(30, egs_pkg::ST_FREE, 0);
        resched(0);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            if (k == n / 2) drain();
            if ($urandom_range(0, 3) != 0)
                set_slot($urandom_range(0, 63), 2'($urandom), $urandom_range(0, 255));
            else if ($urandom_range(0, 1) == 0)
                resched(0);
            else
                resched($urandom_range(0, 510));
        end
        burst = 1'b0;
    endtask

    initial begin
        pick_t exp_p;
        pick_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[16:0];
                got = {m_axis_tdata[5:0], m_axis_tdata[14:6], m_axis_tdata[15],
                       m_axis_tdata[16]};
                if (pick_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
                end else begin
                    exp_p = pick_q.pop_front();
                    if (got !== exp_p) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp slot %0d q %0d ep %0d f %0d, got slot %0d q %0d ep %0d f %0d",
                                     exp_p.next_slot, exp_p.quantum, exp_p.epoch, exp_p.found,
                                     got.next_slot, got.quantum, got.epoch, got.found);
                    end
                end
            end
        end
    end

    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_state[i] = egs_pkg::ST_FREE;
            tbl_prio[i] = '0;
            tbl_quant[i] = '0;
            tbl_good[i] = '0;
        end
        run_slot = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_extremes();
        test_ties_and_current();
        test_random(1030);
        drain();
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && pick_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
